@@ src/rgbhsv_pkg.sv @@
// Shared types, widths and the restoring divide step for the RGB to HSV / gray converter.
package rgbhsv_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned NumW   = 17;   // dividend width, up to 360 * 255
    localparam int unsigned QuotW  = 9;    // quotient width, up to 359
    localparam int unsigned Steps  = QuotW;
    localparam int unsigned SdataW = 24;
    localparam int unsigned MdataW = 32;

    // Mode register codes
    localparam logic MODE_GRAY = 1'b0;
    localparam logic MODE_HSV  = 1'b1;
    localparam logic MODE_RST  = MODE_HSV;

    // Gray weights and divisor
    localparam logic [NumW-1:0]  GRAY_WR  = NumW'(30);
    localparam logic [NumW-1:0]  GRAY_WG  = NumW'(59);
    localparam logic [NumW-1:0]  GRAY_WB  = NumW'(11);
    localparam logic [ChanW-1:0] GRAY_DIV = ChanW'(100);

    // Partial state of one division lane
    typedef struct packed {
        logic [ChanW-1:0] rem;    // partial remainder, always below den
        logic [QuotW-1:0] low;    // dividend bits still to shift in
        logic [QuotW-1:0] quot;   // quotient bits so far
        logic [ChanW-1:0] den;
    } div_lane_t;

    // Data that rides alongside the divider
    typedef struct packed {
        logic [ChanW-1:0] bright;
    } div_side_t;

    // Load a lane: quotient fits in QuotW bits, so the top bits start as remainder
    function automatic div_lane_t div_load(input logic [NumW-1:0] num,
                                           input logic [ChanW-1:0] den);
        div_lane_t l;
        l.rem  = num[NumW-1:QuotW];
        l.low  = num[QuotW-1:0];
        l.quot = '0;
        l.den  = den;
        return l;
    endfunction

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic div_lane_t div_step(input div_lane_t l);
        div_lane_t     n;
        logic [ChanW:0] t;
        logic [ChanW:0] d;
        logic           ge;
        t      = {l.rem, l.low[QuotW-1]};
        d      = {1'b0, l.den};
        ge     = (t >= d);
        n.rem  = ge ? ChanW'(t - d) : t[ChanW-1:0];
        n.low  = {l.low[QuotW-2:0], 1'b0};
        n.quot = {l.quot[QuotW-2:0], ge};
        n.den  = l.den;
        return n;
    endfunction

endpackage

@@ src/rgb_to_hsv_or_gray_pixel_top.sv @@
// Top level of the RGB pixel converter: weighted gray or HSV, one pixel per clock.
//
// Input stream s_*: one RGB pixel per word. Output stream m_*: one result word
// per input word, in order. cfg_wr_en / cfg_wr_data write the one-bit mode
// register (0 gray, 1 HSV); write it only while no pixel is in flight.
// In HSV mode the result holds hue in degrees, saturation scaled to 255 and
// value (largest channel). In gray mode it holds floor((30R+59G+11B)/100) with
// saturation and value zero.
// Pipeline: eleven register stages, two of max/min and dividend setup, then
// nine of a restoring divider that yields one quotient bit per stage.
// Throughput: one word per clock. The whole pipeline advances together when
// the output register is empty or being taken; s_tready follows that.
// When the receiver stalls, every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits and sets the mode to HSV.
module rgb_to_hsv_or_gray_pixel_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,   // conversion_mode
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rgbhsv_pkg::SdataW-1:0]    s_tdata,       // red, green, blue
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rgbhsv_pkg::MdataW-1:0]    m_tdata        // hue_or_gray, saturation,
                                                            // brightness, zero pad
);

    localparam int unsigned CW = rgbhsv_pkg::ChanW;
    localparam int unsigned NW = rgbhsv_pkg::NumW;

    logic mode_reg;
    logic en;

    logic [CW-1:0] red, green, blue;
    logic [CW-1:0] mx, mn;

    // Stage 1 registers
    logic          s1_valid_reg;
    logic [CW-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [CW-1:0] s1_max_reg, s1_delta_reg;
    logic          s1_mode_reg, s1_bmax_reg, s1_gmax_reg;

    // Stage 2 registers
    logic          s2_valid_reg;
    logic [NW-1:0] s2_num_a_reg, s2_num_b_reg;
    logic [CW-1:0] s2_den_a_reg, s2_den_b_reg;
    rgbhsv_pkg::div_side_t s2_side_reg;

    logic signed [9:0]  diff;
    logic signed [18:0] hue_num;
    logic [NW-1:0]      gray_num;
    logic [NW-1:0]      sat_num;

    logic [rgbhsv_pkg::QuotW-1:0] quot_a, quot_b;
    rgbhsv_pkg::div_side_t        out_side;

    // Pipeline advances when the output word is absent or taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rgbhsv_pkg::MODE_RST;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Unpack and find max / min
    assign red   = s_tdata[CW-1:0];
    assign green = s_tdata[2*CW-1:CW];
    assign blue  = s_tdata[3*CW-1:2*CW];

    always_comb begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
    end

    // Stage 1: channels, max, delta, winning channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_max_reg   <= mx;
            s1_delta_reg <= mx - mn;
            s1_mode_reg  <= mode_reg;
            s1_bmax_reg  <= (blue == mx);
            s1_gmax_reg  <= (green == mx);
        end
    end

    // Hue dividend: blue beats green beats red on a tied maximum
    always_comb begin
        if (s1_bmax_reg) begin
            diff    = $signed({2'b0, s1_red_reg}) - $signed({2'b0, s1_green_reg});
            hue_num = 19'sd240 * $signed({11'b0, s1_delta_reg})
                    + 19'sd60 * $signed({{9{diff[9]}}, diff});
        end else if (s1_gmax_reg) begin
            diff    = $signed({2'b0, s1_blue_reg}) - $signed({2'b0, s1_red_reg});
            hue_num = 19'sd120 * $signed({11'b0, s1_delta_reg})
                    + 19'sd60 * $signed({{9{diff[9]}}, diff});
        end else begin
            diff    = $signed({2'b0, s1_green_reg}) - $signed({2'b0, s1_blue_reg});
            hue_num = 19'sd60 * $signed({{9{diff[9]}}, diff});
            if (diff < 0) begin
                hue_num = hue_num + 19'sd360 * $signed({11'b0, s1_delta_reg});
            end
        end
    end

    assign gray_num = rgbhsv_pkg::GRAY_WR * {{(NW-CW){1'b0}}, s1_red_reg}
                    + rgbhsv_pkg::GRAY_WG * {{(NW-CW){1'b0}}, s1_green_reg}
                    + rgbhsv_pkg::GRAY_WB * {{(NW-CW){1'b0}}, s1_blue_reg};
    assign sat_num  = NW'(255) * {{(NW-CW){1'b0}}, s1_delta_reg};

    // Stage 2: dividends and divisors; zero cases go through as 0 / 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s1_mode_reg == rgbhsv_pkg::MODE_GRAY) begin
                s2_num_a_reg       <= gray_num;
                s2_den_a_reg       <= rgbhsv_pkg::GRAY_DIV;
                s2_num_b_reg       <= '0;
                s2_den_b_reg       <= CW'(1);
                s2_side_reg.bright <= '0;
            end else begin
                if (s1_delta_reg == '0) begin
                    s2_num_a_reg <= '0;
                    s2_den_a_reg <= CW'(1);
                    s2_num_b_reg <= '0;
                    s2_den_b_reg <= CW'(1);
                end else begin
                    s2_num_a_reg <= hue_num[NW-1:0];
                    s2_den_a_reg <= s1_delta_reg;
                    s2_num_b_reg <= sat_num;
                    s2_den_b_reg <= s1_max_reg;
                end
                s2_side_reg.bright <= s1_max_reg;
            end
        end
    end

    // Hue or gray on lane a, saturation on lane b
    rgbhsv_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .num_a     (s2_num_a_reg),
        .den_a     (s2_den_a_reg),
        .num_b     (s2_num_b_reg),
        .den_b     (s2_den_b_reg),
        .in_side   (s2_side_reg),
        .out_valid (m_tvalid),
        .quot_a    (quot_a),
        .quot_b    (quot_b),
        .out_side  (out_side)
    );

    // Result word
    assign m_tdata = {7'b0, out_side.bright, quot_b[CW-1:0], quot_a};

endmodule

@@ src/rgbhsv_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
module rgbhsv_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [rgbhsv_pkg::NumW-1:0]     num_a,
    input  logic [rgbhsv_pkg::ChanW-1:0]    den_a,
    input  logic [rgbhsv_pkg::NumW-1:0]     num_b,
    input  logic [rgbhsv_pkg::ChanW-1:0]    den_b,
    input  rgbhsv_pkg::div_side_t           in_side,
    output logic                            out_valid,
    output logic [rgbhsv_pkg::QuotW-1:0]    quot_a,
    output logic [rgbhsv_pkg::QuotW-1:0]    quot_b,
    output rgbhsv_pkg::div_side_t           out_side
);

    rgbhsv_pkg::div_lane_t lane_a_reg [rgbhsv_pkg::Steps];
    rgbhsv_pkg::div_lane_t lane_b_reg [rgbhsv_pkg::Steps];
    rgbhsv_pkg::div_side_t side_reg   [rgbhsv_pkg::Steps];
    logic [rgbhsv_pkg::Steps-1:0] valid_reg;

    // Valid bits of the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[rgbhsv_pkg::Steps-2:0], in_valid};
        end
    end

    // Divide stages: first stage loads and steps, the rest step
    always_ff @(posedge aclk) begin
        if (en) begin
            lane_a_reg[0] <= rgbhsv_pkg::div_step(rgbhsv_pkg::div_load(num_a, den_a));
            lane_b_reg[0] <= rgbhsv_pkg::div_step(rgbhsv_pkg::div_load(num_b, den_b));
            side_reg[0]   <= in_side;
            for (int i = 1; i < rgbhsv_pkg::Steps; i++) begin
                lane_a_reg[i] <= rgbhsv_pkg::div_step(lane_a_reg[i-1]);
                lane_b_reg[i] <= rgbhsv_pkg::div_step(lane_b_reg[i-1]);
                side_reg[i]   <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[rgbhsv_pkg::Steps-1];
    assign quot_a    = lane_a_reg[rgbhsv_pkg::Steps-1].quot;
    assign quot_b    = lane_b_reg[rgbhsv_pkg::Steps-1].quot;
    assign out_side  = side_reg[rgbhsv_pkg::Steps-1];

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the RGB to HSV / weighted gray pixel converter.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned QUIET_LIMIT = 1000;   // cycles with no handshake on either side
    localparam int unsigned LONG_HOLD   = 64;     // receiver back-pressure stretch
    localparam int unsigned DRAIN_TAIL  = 20;     // extra cycles after the last result

    // One converted pixel as it appears on m_tdata
    typedef struct packed {
        logic [8:0] hue_or_gray;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } pixel_res_t;

    // One row of the directed table; known marks a hand-typed expectation
    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       known;
        pixel_res_t res;
    } pixel_row_t;

    localparam int unsigned NUM_ROWS = 22;

    localparam pixel_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // HSV, straight after reset; black, white, then the three primaries
        '{rgbhsv_pkg::MODE_HSV, 8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   8'd0}},
        '{rgbhsv_pkg::MODE_HSV, 8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   8'd0,   8'd255}},
        '{rgbhsv_pkg::MODE_HSV, 8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd255}},
        '{rgbhsv_pkg::MODE_HSV, 8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 8'd255, 8'd255}},
        '{rgbhsv_pkg::MODE_HSV, 8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 8'd255, 8'd255}},
        // red/green, green/blue and red/blue ties
        '{rgbhsv_pkg::MODE_HSV, 8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  8'd255, 8'd255}},
        '{rgbhsv_pkg::MODE_HSV, 8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 8'd255, 8'd255}},
        '{rgbhsv_pkg::MODE_HSV, 8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 8'd255, 8'd255}},
        // hue wraps, mid grey and a tiny red, then rows left to convert_pixel
        '{rgbhsv_pkg::MODE_HSV, 8'd255, 8'd0,   8'd1,   1'b1, '{9'd359, 8'd255, 8'd255}},
        '{rgbhsv_pkg::MODE_HSV, 8'd128, 8'd128, 8'd128, 1'b1, '{9'd0,   8'd0,   8'd128}},
        '{rgbhsv_pkg::MODE_HSV, 8'd1,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd1}},
        '{rgbhsv_pkg::MODE_HSV, 8'd200, 8'd100, 8'd50,  1'b0, '0},
        '{rgbhsv_pkg::MODE_HSV, 8'd10,  8'd200, 8'd30,  1'b0, '0},
        '{rgbhsv_pkg::MODE_HSV, 8'd17,  8'd3,   8'd250, 1'b0, '0},
        '{rgbhsv_pkg::MODE_HSV, 8'd254, 8'd1,   8'd127, 1'b0, '0},
        // weighted gray
        '{rgbhsv_pkg::MODE_GRAY, 8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0, 8'd0}},
        '{rgbhsv_pkg::MODE_GRAY, 8'd255, 8'd255, 8'd255, 1'b1, '{9'd255, 8'd0, 8'd0}},
        '{rgbhsv_pkg::MODE_GRAY, 8'd255, 8'd0,   8'd0,   1'b1, '{9'd76,  8'd0, 8'd0}},
        '{rgbhsv_pkg::MODE_GRAY, 8'd0,   8'd255, 8'd0,   1'b1, '{9'd150, 8'd0, 8'd0}},
        '{rgbhsv_pkg::MODE_GRAY, 8'd0,   8'd0,   8'd255, 1'b1, '{9'd28,  8'd0, 8'd0}},
        '{rgbhsv_pkg::MODE_GRAY, 8'd100, 8'd150, 8'd200, 1'b0, '0},
        '{rgbhsv_pkg::MODE_GRAY, 8'd1,   8'd2,   8'd3,   1'b0, '0}
    };

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic                            cfg_wr_data = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [rgbhsv_pkg::SdataW-1:0]   s_tdata     = '0;    // red, green, blue
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [rgbhsv_pkg::MdataW-1:0]   m_tdata;     // hue_or_gray, saturation, brightness, pad

    pixel_res_t  expected_pixels [$];
    logic        cur_mode      = rgbhsv_pkg::MODE_RST;
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;
    bit          hold_req      = 1'b0;
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned gray_pixels   = 0;
    int unsigned hsv_pixels    = 0;
    int unsigned quiet_cycles  = 0;

    rgb_to_hsv_or_gray_pixel_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Exact integer conversion of one pixel
    function automatic pixel_res_t convert_pixel(input logic mode, input logic [7:0] red,
                                                 input logic [7:0] green,
                                                 input logic [7:0] blue);
        pixel_res_t res;
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int dl;
        int num;
        r   = int'(red);
        g   = int'(green);
        b   = int'(blue);
        res = '0;
        if (mode == rgbhsv_pkg::MODE_GRAY) begin
            res.hue_or_gray = 9'((30 * r + 59 * g + 11 * b) / 100);
            return res;
        end
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        dl = mx - mn;
        res.brightness = 8'(mx);
        if (mx != 0)
            res.saturation = 8'((255 * dl) / mx);
        if (dl != 0) begin
            // blue wins ties over green, green over red
            if (b == mx)
                num = 240 * dl + 60 * (r - g);
            else if (g == mx)
                num = 120 * dl + 60 * (b - r);
            else begin
                num = 60 * (g - b);
                if (num < 0)
                    num += 360 * dl;
            end
            res.hue_or_gray = 9'(num / dl);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one pixel word and wait for it to be taken
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input bit known, input pixel_res_t res);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(known ? res : convert_pixel(cur_mode, red, green, blue));
        if (cur_mode == rgbhsv_pkg::MODE_GRAY)
            gray_pixels++;
        else
            hsv_pixels++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_mode     = mode;
        @(posedge aclk);
    endtask

    // Random pixel with a bias towards extremes, ties and tiny values
    task automatic random_pixel(output logic [7:0] red, output logic [7:0] green,
                                output logic [7:0] blue);
        logic [7:0] v;
        red   = 8'($urandom);
        green = 8'($urandom);
        blue  = 8'($urandom);
        v     = 8'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            1: begin
                red   = v;
                green = v;
            end
            2: begin
                green = v;
                blue  = v;
            end
            3: begin
                red  = v;
                blue = v;
                if ($urandom_range(0, 1)) green = v;
            end
            4: begin
                red   = 8'($urandom_range(0, 3));
                green = 8'($urandom_range(0, 3));
                blue  = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req  = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        pixel_res_t got;
        pixel_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hue_or_gray = m_tdata[8:0];
            got.saturation  = m_tdata[16:9];
            got.brightness  = m_tdata[24:17];
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $display("[%0t] result word with nothing expected", $realtime);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.hue_or_gray !== want.hue_or_gray)
                    report_mismatch("hue_or_gray", got.hue_or_gray, want.hue_or_gray);
                if (got.saturation !== want.saturation)
                    report_mismatch("saturation", got.saturation, want.saturation);
                if (got.brightness !== want.brightness)
                    report_mismatch("brightness", got.brightness, want.brightness);
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        logic        phase_modes [5];
        int unsigned phase_len   [5];
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;

        phase_modes = '{rgbhsv_pkg::MODE_HSV, rgbhsv_pkg::MODE_GRAY, rgbhsv_pkg::MODE_HSV,
                        rgbhsv_pkg::MODE_GRAY, rgbhsv_pkg::MODE_HSV};
        phase_len   = '{100, 90, 90, 80, 90};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; the first rows rely on the HSV mode out of reset
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED_ROWS[i].mode != cur_mode)
                write_mode(DIRECTED_ROWS[i].mode);
            send_pixel(DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green, DIRECTED_ROWS[i].blue,
                       DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);
        end

        // random phases, alternating mode; the last one runs with no idling
        for (int p = 0; p < 5; p++) begin
            if (phase_modes[p] != cur_mode)
                write_mode(phase_modes[p]);
            if (p == 4) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (int n = 0; n < phase_len[p]; n++) begin
                if (p == 0 && n == 30)
                    hold_req = 1'b1;
                if (p == 1 && n == 40)
                    drain_results();
                random_pixel(r, g, b);
                send_pixel(r, g, b, 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("tb: %0d HSV and %0d gray pixel words sent, %0d result words checked",
                 hsv_pixels, gray_pixels, results_seen);
        $display("tb: mode switched both ways, with random stalls and one long back-pressure hold");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rgbhsv_pkg.sv
src/rgbhsv_div.sv
src/rgb_to_hsv_or_gray_pixel_top.sv
tb/testbench.sv
